FILE: rtl/core/tod_pkg.sv
// Shared types and constants for the time-of-day counter.
`timescale 1ns / 1ps
`default_nettype none

package tod_pkg;

  localparam int unsigned HourW = 5;
  localparam int unsigned MinW  = 6;
  localparam int unsigned SecW  = 6;
  localparam int unsigned AmtW  = 32;
  localparam int unsigned CmdW  = 3;

  localparam logic [HourW-1:0] HourMax = 5'd23;
  localparam logic [MinW-1:0]  MinMax  = 6'd59;
  localparam logic [SecW-1:0]  SecMax  = 6'd59;

  localparam int unsigned SecsPerDay  = 86400;
  localparam int unsigned SecsPerHour = 3600;
  localparam int unsigned SecsPerMin  = 60;

  // Reciprocals, floored, so a quotient is exact or one low.
  localparam int unsigned DayShift  = 48;
  localparam logic [31:0] DayRecip  = 32'((64'd1 << DayShift) / 64'd86400);
  localparam int unsigned HourShift = 24;
  localparam logic [12:0] HourRecip = 13'((32'd1 << HourShift) / 32'd3600);
  localparam int unsigned MinShift  = 16;
  localparam logic [10:0] MinRecip  = 11'((32'd1 << MinShift) / 32'd60);

  typedef enum logic [CmdW-1:0] {
    CMD_TICK_UP   = 3'd0,
    CMD_TICK_DOWN = 3'd1,
    CMD_ADD_SECS  = 3'd2,
    CMD_SET_HOUR  = 3'd3,
    CMD_SET_MIN   = 3'd4,
    CMD_SET_SEC   = 3'd5,
    CMD_LOAD_SECS = 3'd6,
    CMD_LOAD_ALL  = 3'd7
  } tod_cmd_e;

  typedef struct packed {
    tod_cmd_e         cmd;
    logic             neg;
    logic [HourW-1:0] hour_val;
    logic [MinW-1:0]  min_val;
    logic [SecW-1:0]  sec_val;
  } tod_ctl_t;

  // Command with its amount split into hour, minute and second (mod one day).
  typedef struct packed {
    tod_ctl_t         ctl;
    logic [HourW-1:0] amt_hour;
    logic [MinW-1:0]  amt_min;
    logic [SecW-1:0]  amt_sec;
  } tod_item_t;

endpackage

`default_nettype wire

FILE: rtl/core/time_of_day_counter.sv
// Top level of the 24-hour time-of-day counter with stream ports.
`timescale 1ns / 1ps
`default_nettype none

// Each command item yields one result item carrying the time after the command.
// One item is taken per clock while the output is not stalled; each result passes
// through the seven-stage amount pipeline (modulo one day by reciprocal multiply, then
// hour and minute split) followed by the single time register stage, where
// every command is applied. Reset sets the time to 00:00:00.
module time_of_day_counter (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [2:0] command, [34:3] amount, [39:35] hour_value, [45:40] minute_value,
  // [51:46] second_value, [55:52] zero
  input  wire logic [55:0] s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [4:0] hour_now, [10:5] minute_now, [16:11] second_now, [23:17] zero
  output logic [23:0]      m_axis_tdata_o
);
  import tod_pkg::*;

  tod_ctl_t         in_ctl;
  tod_item_t        split_item;
  logic             split_valid, split_ready;
  logic [HourW-1:0] hour_now;
  logic [MinW-1:0]  minute_now;
  logic [SecW-1:0]  second_now;

  assign in_ctl.cmd      = tod_cmd_e'(s_axis_tdata_i[2:0]);
  assign in_ctl.neg      = s_axis_tdata_i[34];
  assign in_ctl.hour_val = s_axis_tdata_i[39:35];
  assign in_ctl.min_val  = s_axis_tdata_i[45:40];
  assign in_ctl.sec_val  = s_axis_tdata_i[51:46];

  tod_amt_split u_split (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_ctl_i    (in_ctl),
    .in_amount_i (s_axis_tdata_i[34:3]),
    .out_valid_o (split_valid),
    .out_ready_i (split_ready),
    .out_item_o  (split_item)
  );

  tod_clock_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (split_valid),
    .in_ready_o  (split_ready),
    .in_item_i   (split_item),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .hour_o      (hour_now),
    .minute_o    (minute_now),
    .second_o    (second_now)
  );

  assign m_axis_tdata_o = {7'd0, second_now, minute_now, hour_now};

endmodule

`default_nettype wire

FILE: rtl/core/tod_amt_split.sv
// Pipeline that reduces the amount modulo one day and splits it into h/m/s.
`timescale 1ns / 1ps
`default_nettype none

module tod_amt_split (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire tod_pkg::tod_ctl_t       in_ctl_i,
  input  wire logic [tod_pkg::AmtW-1:0] in_amount_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output tod_pkg::tod_item_t           out_item_o
);
  import tod_pkg::*;

  localparam int unsigned Stages = 7;

  logic [Stages-1:0] vld_q;
  logic [Stages-1:0] adv;
  tod_ctl_t          ctl_q [Stages];

  logic [30:0] x0_q, x1_q;
  logic [14:0] q1_q;
  logic [16:0] r2_q, r3_q;
  logic [4:0]  h3_q, h4_q, h5_q, h6_q;
  logic [11:0] rem4_q, rem5_q;
  logic [5:0]  m5_q, m6_q, s6_q;

  logic [62:0] day_prod;
  logic [31:0] day_qm, day_r0;
  logic [16:0] day_r;
  logic [29:0] hour_prod;
  logic [16:0] hour_qm, hour_r0;
  logic [22:0] min_prod;
  logic [11:0] min_qm, min_r0;

  // stage k may load when empty or when its item moves on
  always_comb begin
    adv[Stages-1] = !vld_q[Stages-1] || out_ready_i;
    for (int k = Stages - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign in_ready_o = adv[0];

  always_comb begin
    day_prod  = {32'd0, x0_q} * {31'd0, DayRecip};
    day_qm    = {17'd0, q1_q} * 32'(SecsPerDay);
    day_r0    = {1'b0, x1_q} - day_qm;
    day_r     = (day_r0 >= 32'(SecsPerDay)) ? 17'(day_r0 - 32'(SecsPerDay)) : day_r0[16:0];
    hour_prod = {13'd0, r2_q} * {17'd0, HourRecip};
    hour_qm   = {12'd0, h3_q} * 17'(SecsPerHour);
    hour_r0   = r3_q - hour_qm;
    min_prod  = {11'd0, rem4_q} * {12'd0, MinRecip};
    min_qm    = {6'd0, m5_q} * 12'(SecsPerMin);
    min_r0    = rem5_q - min_qm;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < Stages; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      ctl_q[0] <= in_ctl_i;
    end
    for (int k = 1; k < Stages; k++) begin
      if (adv[k]) begin
        ctl_q[k] <= ctl_q[k-1];
      end
    end
    if (adv[0]) begin
      x0_q <= in_amount_i[AmtW-1] ? '0 : in_amount_i[30:0];
    end
    if (adv[1]) begin
      x1_q <= x0_q;
      q1_q <= day_prod[62:48];
    end
    if (adv[2]) begin
      r2_q <= day_r;
    end
    if (adv[3]) begin
      r3_q <= r2_q;
      h3_q <= hour_prod[28:24];
    end
    if (adv[4]) begin
      if (hour_r0 >= 17'(SecsPerHour)) begin
        h4_q   <= h3_q + 5'd1;
        rem4_q <= 12'(hour_r0 - 17'(SecsPerHour));
      end else begin
        h4_q   <= h3_q;
        rem4_q <= hour_r0[11:0];
      end
    end
    if (adv[5]) begin
      h5_q   <= h4_q;
      rem5_q <= rem4_q;
      m5_q   <= min_prod[21:16];
    end
    if (adv[6]) begin
      h6_q <= h5_q;
      if (min_r0 >= 12'(SecsPerMin)) begin
        m6_q <= m5_q + 6'd1;
        s6_q <= 6'(min_r0 - 12'(SecsPerMin));
      end else begin
        m6_q <= m5_q;
        s6_q <= min_r0[5:0];
      end
    end
  end

  assign out_valid_o         = vld_q[Stages-1];
  assign out_item_o.ctl      = ctl_q[Stages-1];
  assign out_item_o.amt_hour = h6_q;
  assign out_item_o.amt_min  = m6_q;
  assign out_item_o.amt_sec  = s6_q;

endmodule

`default_nettype wire

FILE: rtl/core/tod_clock_core.sv
// Time-of-day registers, command execution and result register.
`timescale 1ns / 1ps
`default_nettype none

module tod_clock_core (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire tod_pkg::tod_item_t        in_item_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [tod_pkg::HourW-1:0]      hour_o,
  output logic [tod_pkg::MinW-1:0]       minute_o,
  output logic [tod_pkg::SecW-1:0]       second_o
);
  import tod_pkg::*;

  logic             out_vld_q;
  logic [HourW-1:0] hour_q, hour_d;
  logic [MinW-1:0]  min_q, min_d;
  logic [SecW-1:0]  sec_q, sec_d;

  logic [SecW:0]    sec_sum;
  logic [MinW:0]    min_sum;
  logic [HourW:0]   hour_sum;
  logic             sec_cy, min_cy;
  logic [SecW-1:0]  add_sec;
  logic [MinW-1:0]  add_min;
  logic [HourW-1:0] add_hour;
  logic             accept;
  tod_ctl_t         ctl;

  assign ctl        = in_item_i.ctl;
  assign in_ready_o = !out_vld_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // mixed-radix add of the split amount
  always_comb begin
    sec_sum  = {1'b0, sec_q} + {1'b0, in_item_i.amt_sec};
    sec_cy   = sec_sum >= 7'(SecsPerMin);
    add_sec  = sec_cy ? 6'(sec_sum - 7'(SecsPerMin)) : sec_sum[SecW-1:0];
    min_sum  = {1'b0, min_q} + {1'b0, in_item_i.amt_min} + {6'd0, sec_cy};
    min_cy   = min_sum >= 7'(SecsPerMin);
    add_min  = min_cy ? 6'(min_sum - 7'(SecsPerMin)) : min_sum[MinW-1:0];
    hour_sum = {1'b0, hour_q} + {1'b0, in_item_i.amt_hour} + {5'd0, min_cy};
    add_hour = (hour_sum > {1'b0, HourMax}) ? 5'(hour_sum - 6'd24) : hour_sum[HourW-1:0];
  end

  always_comb begin
    hour_d = hour_q;
    min_d  = min_q;
    sec_d  = sec_q;
    case (ctl.cmd)
      CMD_TICK_UP: begin
        if (sec_q < SecMax) begin
          sec_d = sec_q + 6'd1;
        end else begin
          sec_d = '0;
          if (min_q < MinMax) begin
            min_d = min_q + 6'd1;
          end else begin
            min_d  = '0;
            hour_d = (hour_q < HourMax) ? hour_q + 5'd1 : '0;
          end
        end
      end
      CMD_TICK_DOWN: begin
        if (sec_q != '0) begin
          sec_d = sec_q - 6'd1;
        end else begin
          sec_d = SecMax;
          if (min_q != '0) begin
            min_d = min_q - 6'd1;
          end else begin
            min_d  = MinMax;
            hour_d = (hour_q != '0) ? hour_q - 5'd1 : HourMax;
          end
        end
      end
      CMD_ADD_SECS: begin
        if (!ctl.neg) begin
          hour_d = add_hour;
          min_d  = add_min;
          sec_d  = add_sec;
        end
      end
      CMD_SET_HOUR: begin
        if (ctl.hour_val <= HourMax) hour_d = ctl.hour_val;
      end
      CMD_SET_MIN: begin
        if (ctl.min_val <= MinMax) min_d = ctl.min_val;
      end
      CMD_SET_SEC: begin
        if (ctl.sec_val <= SecMax) sec_d = ctl.sec_val;
      end
      CMD_LOAD_SECS: begin
        // negative amounts arrive already split as zero
        hour_d = in_item_i.amt_hour;
        min_d  = in_item_i.amt_min;
        sec_d  = in_item_i.amt_sec;
      end
      CMD_LOAD_ALL: begin
        if (ctl.hour_val <= HourMax && ctl.min_val <= MinMax && ctl.sec_val <= SecMax) begin
          hour_d = ctl.hour_val;
          min_d  = ctl.min_val;
          sec_d  = ctl.sec_val;
        end else begin
          hour_d = '0;
          min_d  = '0;
          sec_d  = '0;
        end
      end
      default: begin
        hour_d = hour_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      hour_q    <= '0;
      min_q     <= '0;
      sec_q     <= '0;
    end else begin
      if (in_ready_o) begin
        out_vld_q <= in_valid_i;
      end
      if (accept) begin
        hour_q <= hour_d;
        min_q  <= min_d;
        sec_q  <= sec_d;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign hour_o      = hour_q;
  assign minute_o    = min_q;
  assign second_o    = sec_q;

endmodule

`default_nettype wire

FILE: test/time_of_day_counter_tb.sv
`timescale 1ns / 1ps
// Testbench for the time-of-day counter: directed command table, then random commands.

module time_of_day_counter_tb;
  import tod_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned NumRandom  = 850;
  localparam int unsigned NumRows    = 28;

  typedef struct packed {
    logic [SecW-1:0]  sec;
    logic [MinW-1:0]  min;
    logic [HourW-1:0] hour;
  } tod_time_t;

  typedef struct packed {
    tod_cmd_e         cmd;
    logic [AmtW-1:0]  amount;
    logic [HourW-1:0] hour_val;
    logic [MinW-1:0]  min_val;
    logic [SecW-1:0]  sec_val;
    logic             known;
    logic [HourW-1:0] want_hour;
    logic [MinW-1:0]  want_min;
    logic [SecW-1:0]  want_sec;
  } cmd_row_t;

  // hour/min/sec columns: values sent, then the time expected when known is set
  cmd_row_t cmd_rows [NumRows] = '{
    '{CMD_TICK_DOWN, 32'd0,          5'd0,  6'd0,  6'd0,  1'b1, 5'd23, 6'd59, 6'd59},
    '{CMD_TICK_UP,   32'd0,          5'd0,  6'd0,  6'd0,  1'b1, 5'd0,  6'd0,  6'd0},
    '{CMD_LOAD_SECS, 32'd86399,      5'd0,  6'd0,  6'd0,  1'b1, 5'd23, 6'd59, 6'd59},
    '{CMD_LOAD_SECS, 32'd86400,      5'd0,  6'd0,  6'd0,  1'b1, 5'd0,  6'd0,  6'd0},
    '{CMD_LOAD_SECS, 32'h8000_0000,  5'd0,  6'd0,  6'd0,  1'b1, 5'd0,  6'd0,  6'd0},
    '{CMD_LOAD_SECS, 32'h7FFF_FFFF,  5'd0,  6'd0,  6'd0,  1'b0, 5'd0,  6'd0,  6'd0},
    '{CMD_LOAD_SECS, 32'hFFFF_FFFF,  5'd31, 6'd63, 6'd63, 1'b1, 5'd0,  6'd0,  6'd0},
    '{CMD_LOAD_ALL,  32'd0,          5'd23, 6'd59, 6'd59, 1'b1, 5'd23, 6'd59, 6'd59},
    '{CMD_ADD_SECS,  32'd1,          5'd0,  6'd0,  6'd0,  1'b1, 5'd0,  6'd0,  6'd0},
    '{CMD_LOAD_ALL,  32'hFFFF_FFFF,  5'd23, 6'd59, 6'd59, 1'b1, 5'd23, 6'd59, 6'd59},
    '{CMD_ADD_SECS,  32'h7FFF_FFFF,  5'd0,  6'd0,  6'd0,  1'b0, 5'd0,  6'd0,  6'd0},
    '{CMD_ADD_SECS,  32'h8000_0000,  5'd31, 6'd63, 6'd63, 1'b0, 5'd0,  6'd0,  6'd0},
    '{CMD_SET_HOUR,  32'hFFFF_FFFF,  5'd23, 6'd63, 6'd63, 1'b0, 5'd0,  6'd0,  6'd0},
    '{CMD_SET_HOUR,  32'd0,          5'd24, 6'd0,  6'd0,  1'b0, 5'd0,  6'd0,  6'd0},
    '{CMD_SET_HOUR,  32'd0,          5'd31, 6'd0,  6'd0,  1'b0, 5'd0,  6'd0,  6'd0},
    '{CMD_SET_MIN,   32'd0,          5'd0,  6'd59, 6'd0,  1'b0, 5'd0,  6'd0,  6'd0},
    '{CMD_SET_MIN,   32'd0,          5'd0,  6'd60, 6'd0,  1'b0, 5'd0,  6'd0,  6'd0},
    '{CMD_SET_MIN,   32'h8000_0000,  5'd31, 6'd63, 6'd63, 1'b0, 5'd0,  6'd0,  6'd0},
    '{CMD_SET_SEC,   32'd0,          5'd0,  6'd0,  6'd0,  1'b0, 5'd0,  6'd0,  6'd0},
    '{CMD_SET_SEC,   32'd0,          5'd0,  6'd0,  6'd60, 1'b0, 5'd0,  6'd0,  6'd0},
    '{CMD_SET_SEC,   32'h7FFF_FFFF,  5'd31, 6'd63, 6'd63, 1'b0, 5'd0,  6'd0,  6'd0},
    '{CMD_LOAD_ALL,  32'd0,          5'd24, 6'd0,  6'd0,  1'b1, 5'd0,  6'd0,  6'd0},
    '{CMD_LOAD_ALL,  32'd0,          5'd12, 6'd59, 6'd59, 1'b1, 5'd12, 6'd59, 6'd59},
    '{CMD_TICK_UP,   32'hFFFF_FFFF,  5'd31, 6'd63, 6'd63, 1'b1, 5'd13, 6'd0,  6'd0},
    '{CMD_TICK_DOWN, 32'h8000_0000,  5'd31, 6'd63, 6'd63, 1'b1, 5'd12, 6'd59, 6'd59},
    '{CMD_LOAD_ALL,  32'd0,          5'd0,  6'd60, 6'd0,  1'b1, 5'd0,  6'd0,  6'd0},
    '{CMD_LOAD_ALL,  32'd0,          5'd0,  6'd0,  6'd60, 1'b1, 5'd0,  6'd0,  6'd0},
    '{CMD_LOAD_ALL,  32'd0,          5'd31, 6'd63, 6'd63, 1'b1, 5'd0,  6'd0,  6'd0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [55:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;

  tod_time_t   clock_now = '0;
  tod_time_t   pending_times [$];
  tod_time_t   got_time;
  tod_time_t   want_time;
  int unsigned errors = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        hold_go = 1'b0;
  logic        hold_rx = 1'b0;

  time_of_day_counter i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic tod_time_t split_total(input longint unsigned total);
    longint unsigned rem;
    tod_time_t t;
    rem = total % SecsPerDay;
    t.hour = HourW'(rem / SecsPerHour);
    rem = rem % SecsPerHour;
    t.min = MinW'(rem / SecsPerMin);
    t.sec = SecW'(rem % SecsPerMin);
    return t;
  endfunction

  function automatic tod_time_t next_time(input tod_time_t t, input tod_cmd_e cmd,
                                          input logic [AmtW-1:0] amt,
                                          input logic [HourW-1:0] hv,
                                          input logic [MinW-1:0] mv,
                                          input logic [SecW-1:0] sv);
    longint unsigned total;
    total = longint'(t.hour) * SecsPerHour + longint'(t.min) * SecsPerMin + longint'(t.sec);
    case (cmd)
      CMD_TICK_UP: begin
        if (t.sec < SecMax) begin
          t.sec = t.sec + 6'd1;
        end else begin
          t.sec = '0;
          if (t.min < MinMax) begin
            t.min = t.min + 6'd1;
          end else begin
            t.min = '0;
            t.hour = (t.hour < HourMax) ? t.hour + 5'd1 : 5'd0;
          end
        end
      end
      CMD_TICK_DOWN: begin
        if (t.sec != 0) begin
          t.sec = t.sec - 6'd1;
        end else begin
          t.sec = SecMax;
          if (t.min != 0) begin
            t.min = t.min - 6'd1;
          end else begin
            t.min = MinMax;
            t.hour = (t.hour != 0) ? t.hour - 5'd1 : HourMax;
          end
        end
      end
      CMD_ADD_SECS: begin
        if (!amt[AmtW-1]) t = split_total(total + longint'(amt));
      end
      CMD_SET_HOUR: begin
        if (hv <= HourMax) t.hour = hv;
      end
      CMD_SET_MIN: begin
        if (mv <= MinMax) t.min = mv;
      end
      CMD_SET_SEC: begin
        if (sv <= SecMax) t.sec = sv;
      end
      CMD_LOAD_SECS: begin
        t = split_total(amt[AmtW-1] ? 64'd0 : longint'(amt));
      end
      default: begin
        if (hv <= HourMax && mv <= MinMax && sv <= SecMax) begin
          t.hour = hv;
          t.min = mv;
          t.sec = sv;
        end else begin
          t = '0;
        end
      end
    endcase
    return t;
  endfunction

  task automatic send_cmd(input tod_cmd_e cmd, input logic [AmtW-1:0] amt,
                          input logic [HourW-1:0] hv, input logic [MinW-1:0] mv,
                          input logic [SecW-1:0] sv, input logic known,
                          input tod_time_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {4'b0, sv, mv, hv, amt, cmd};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    clock_now = next_time(clock_now, cmd, amt, hv, mv, sv);
    pending_times.push_back(known ? want : clock_now);
  endtask

  task automatic check_field(input string what, input int unsigned want, input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t %s: expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  // receiver
  always @(posedge clk_i) begin
    m_axis_tready_i <= !hold_rx && ($urandom_range(99) >= recv_idle_pct);
  end

  // long hold-off while the sender keeps offering items
  initial begin
    wait (hold_go);
    @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (150) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got_time = m_axis_tdata_o[16:0];
      if (pending_times.size() == 0) begin
        errors++;
        $display("%0t unexpected item: expected none, actual %0d:%0d:%0d", $time,
                 got_time.hour, got_time.min, got_time.sec);
      end else begin
        want_time = pending_times.pop_front();
        check_field("hour_now", want_time.hour, got_time.hour);
        check_field("minute_now", want_time.min, got_time.min);
        check_field("second_now", want_time.sec, got_time.sec);
        check_field("pad", 0, m_axis_tdata_o[23:17]);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    tod_time_t        want;
    tod_cmd_e         cmd;
    logic [AmtW-1:0]  amt;
    logic [HourW-1:0] hv;
    logic [MinW-1:0]  mv;
    logic [SecW-1:0]  sv;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 16;
    recv_idle_pct <= 86;
    foreach (cmd_rows[i]) begin
      want.hour = cmd_rows[i].want_hour;
      want.min = cmd_rows[i].want_min;
      want.sec = cmd_rows[i].want_sec;
      send_cmd(cmd_rows[i].cmd, cmd_rows[i].amount, cmd_rows[i].hour_val,
               cmd_rows[i].min_val, cmd_rows[i].sec_val, cmd_rows[i].known, want);
    end

    for (int n = 0; n < NumRandom; n++) begin
      if (n == 300) begin
        send_idle_pct = 86;
        recv_idle_pct <= 16;
      end
      if (n == 600) begin
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        hold_go = 1'b1;
      end
      cmd = tod_cmd_e'($urandom_range(7));
      case ($urandom_range(3))
        0: amt = $urandom_range(3 * SecsPerDay);
        1: amt = $urandom;
        2: amt = ~32'($urandom_range(99));
        default: amt = 32'(SecsPerDay * $urandom_range(24855)) + $urandom_range(2) - 1;
      endcase
      hv = ($urandom_range(9) < 8) ? 5'($urandom_range(23)) : 5'($urandom_range(31, 24));
      mv = ($urandom_range(9) < 8) ? 6'($urandom_range(59)) : 6'($urandom_range(63, 60));
      sv = ($urandom_range(9) < 8) ? 6'($urandom_range(59)) : 6'($urandom_range(63, 60));
      send_cmd(cmd, amt, hv, mv, sv, 1'b0, '0);
    end
    s_axis_tvalid_i <= 1'b0;

    while (pending_times.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
